>>> rtl/core/solar_to_lunar_date_core_defines.svh
// Assertion macros shared by the solar to lunar date converter RTL.
`ifndef SOLAR_TO_LUNAR_DATE_CORE_DEFINES_SVH
`define SOLAR_TO_LUNAR_DATE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define S2L_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define S2L_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/s2l_pkg.sv
// Types, constants and the lunar year table for the solar to lunar date converter.
`timescale 1ns / 1ps
`default_nettype none

package s2l_pkg;

  localparam logic [11:0] BaseYear = 12'd1900;
  localparam logic [11:0] LastYear = 12'd2050;
  localparam int unsigned RomWords = 151;
  localparam int unsigned RomIdxW  = $clog2(RomWords);
  localparam logic [8:0]  YearBaseLen = 9'd348;
  localparam logic [4:0]  DayOffset   = 5'd30;
  localparam logic [4:0]  MaxLunarDay = 5'd30;
  localparam logic [3:0]  LastMonth   = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_OFFSET,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } s2l_state_e;

  // Bits 15..4: month 1..12 is long; bits 3..0: leap month; bit 16: leap month is long.
  localparam logic [16:0] LUNAR_ROM [RomWords] = '{
    17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
    17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
    17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
    17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
    17'h0ea50, 17'h06e95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
    17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
    17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
    17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
    17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
    17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b6a0, 17'h195a6,
    17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
    17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
    17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
    17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
    17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
    17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
    17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04bd7, 17'h04ad0, 17'h0a4d0,
    17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
    17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63
  };

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] greg_month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      r = 5'd30;
      4'd2:                                         r = leap ? 5'd29 : 5'd28;
      default:                                      r = 5'd0;
    endcase
    return r;
  endfunction

  // Gregorian leap rule, valid for years 1900 to 2050 only.
  function automatic logic greg_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != BaseYear);
  endfunction

  function automatic logic [4:0] leap_len(input logic [16:0] w);
    logic [4:0] r;
    if (w[3:0] == 4'h0) begin
      r = 5'd0;
    end else begin
      r = w[16] ? 5'd30 : 5'd29;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/solar_to_lunar_date_core.sv
// Gregorian to Chinese lunar date converter for the years 1900 to 2050.
//
// Usage: a Gregorian date is offered on the input channel (in_valid_i /
// in_ready_o with solar_year_i, solar_month_i, solar_day_i). One result
// transfer follows on the output channel (out_valid_o / out_ready_i) for
// every input transfer, in order. An illegal or out of range date gives
// valid_res_o = 0 with all other result fields zero.
// Steps: an illegal date goes from the scale step straight to the finish
// step. A legal date passes the scale and offset steps, then walks past
// n lunar years (at most 150) and takes j month steps (at most 13:
// twelve months and one leap month) before the finish step.
// New items: in_ready_o is high only while the converter is idle, so a new
// item is accepted only once the previous one has left the finish step.
// The walk over the lunar table uses one subtract and compare unit, which
// takes one table year, or one month, per cycle.
// Reset: the converter returns to idle and no result is pending.
// Stall: a result waits in the output register until it is taken; a new
// item may be accepted meanwhile, and its finished result then holds in the
// last step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "solar_to_lunar_date_core_defines.svh"

module solar_to_lunar_date_core #(
  parameter int unsigned TABLE_YEARS = 151
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [11:0] solar_year_i,
  input  wire logic [3:0]  solar_month_i,
  input  wire logic [4:0]  solar_day_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             valid_res_o,
  output logic [11:0]      lunar_year_o,
  output logic [3:0]       lunar_month_o,
  output logic [4:0]       lunar_day_o,
  output logic             is_leap_month_o
);
  import s2l_pkg::*;

  localparam int unsigned LastIdx =
      ((TABLE_YEARS < RomWords) ? TABLE_YEARS : RomWords) - 1;

  s2l_state_e state_q, state_d;

  logic        out_valid_q, out_valid_d;
  logic [11:0] y_q, y_d;
  logic [3:0]  m_q, m_d;
  logic [4:0]  d_q, d_d;
  logic        ok_q, ok_d;
  logic [15:0] rem_q, rem_d;
  logic [11:0] ly_q, ly_d;
  logic [16:0] w_q, w_d;
  logic [3:0]  mo_q, mo_d;
  logic        leap_ph_q, leap_ph_d;
  logic [3:0]  res_m_q, res_m_d;
  logic [4:0]  res_d_q, res_d_d;
  logic        res_leap_q, res_leap_d;
  logic        res_ok_q, res_ok_d;
  logic        o_res_q, o_res_d;
  logic [11:0] o_year_q, o_year_d;
  logic [3:0]  o_month_q, o_month_d;
  logic [4:0]  o_day_q, o_day_d;
  logic        o_leap_q, o_leap_d;

  logic        in_xfer;
  logic        out_free;
  logic        date_ok;
  logic [7:0]  k;
  logic [5:0]  leaps;
  logic [16:0] offset_sum;
  logic [11:0] idx_raw;
  logic [RomIdxW-1:0] rom_idx;
  logic [16:0] rom_w;
  logic [8:0]  year_len;
  logic [8:0]  sub_len;
  logic [16:0] diff;
  logic        gt;
  logic        year_more;
  logic        month_last;
  logic        month_done;
  logic        illegal_out;
  logic        legal_out;
  logic        res_zero;
  logic        res_in_range;
  logic        ly_in_table;
  logic        mo_in_year;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    date_ok = (solar_year_i inside {[BaseYear:LastYear]}) &&
              (solar_month_i inside {[4'd1:LastMonth]}) &&
              !((solar_year_i == BaseYear) && (solar_month_i == 4'd1)) &&
              (solar_day_i != 5'd0) &&
              (solar_day_i <= greg_month_len(solar_month_i, greg_leap(solar_year_i)));
  end

  // Leap days in the Gregorian years from 1900 up to the year before y_q.
  assign k          = 8'(y_q - BaseYear);
  assign leaps      = (k == 8'd0) ? 6'd0 : 6'((k - 8'd1) >> 2);
  assign offset_sum = 17'(rem_q) + 17'(leaps) + 17'(days_before_month(m_q)) +
                      17'((m_q > 4'd2) && greg_leap(y_q)) + 17'(d_q) - 17'(DayOffset);

  always_comb begin
    idx_raw = ly_q - BaseYear;
    if (idx_raw > 12'(LastIdx)) begin
      idx_raw = 12'(LastIdx);
    end
  end
  assign rom_idx  = idx_raw[RomIdxW-1:0];
  assign rom_w    = LUNAR_ROM[rom_idx];
  assign year_len = YearBaseLen + 9'($countones(rom_w[15:4])) + 9'(leap_len(rom_w));

  // The shared subtract and compare unit serves both the year and the month walk.
  always_comb begin
    if (state_q == ST_YEAR) begin
      sub_len = year_len;
    end else if (leap_ph_q) begin
      sub_len = 9'(leap_len(w_q));
    end else begin
      sub_len = w_q[5'd16 - {1'b0, mo_q}] ? 9'd30 : 9'd29;
    end
  end
  assign diff = {1'b0, rem_q} - 17'(sub_len);
  assign gt   = !diff[16] && (diff[15:0] != 16'd0);

  assign year_more  = gt && (ly_q < LastYear);
  assign month_last = (leap_ph_q || (mo_q != w_q[3:0])) && (mo_q == LastMonth);
  assign month_done = !gt || month_last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ok_q ? ST_OFFSET : ST_FINISH;
      end
      ST_OFFSET: begin
        state_d = ST_YEAR;
      end
      ST_YEAR: begin
        if (!year_more) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (month_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    y_d        = y_q;
    m_d        = m_q;
    d_d        = d_q;
    ok_d       = ok_q;
    rem_d      = rem_q;
    ly_d       = ly_q;
    w_d        = w_q;
    mo_d       = mo_q;
    leap_ph_d  = leap_ph_q;
    res_m_d    = res_m_q;
    res_d_d    = res_d_q;
    res_leap_d = res_leap_q;
    res_ok_d   = res_ok_q;
    o_res_d    = o_res_q;
    o_year_d   = o_year_q;
    o_month_d  = o_month_q;
    o_day_d    = o_day_q;
    o_leap_d   = o_leap_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          y_d  = solar_year_i;
          m_d  = solar_month_i;
          d_d  = solar_day_i;
          ok_d = date_ok;
        end
      end
      ST_SCALE: begin
        rem_d      = 16'(16'(k) * 16'd365);
        ly_d       = ok_q ? BaseYear : 12'd0;
        res_ok_d   = ok_q;
        res_m_d    = 4'd0;
        res_d_d    = 5'd0;
        res_leap_d = 1'b0;
      end
      ST_OFFSET: begin
        rem_d = offset_sum[15:0];
      end
      ST_YEAR: begin
        if (year_more) begin
          rem_d = diff[15:0];
          ly_d  = ly_q + 12'd1;
        end else begin
          w_d       = rom_w;
          mo_d      = 4'd1;
          leap_ph_d = 1'b0;
        end
      end
      ST_MONTH: begin
        if (!gt) begin
          res_m_d    = mo_q;
          res_d_d    = rem_q[4:0];
          res_leap_d = leap_ph_q;
        end else begin
          rem_d = diff[15:0];
          if (!leap_ph_q && (mo_q == w_q[3:0])) begin
            leap_ph_d = 1'b1;
          end else begin
            leap_ph_d = 1'b0;
            if (mo_q == LastMonth) begin
              // The days run past the whole year: saturate on the last month.
              res_m_d    = LastMonth;
              res_d_d    = (diff[15:0] > 16'(MaxLunarDay)) ? MaxLunarDay : diff[4:0];
              res_leap_d = 1'b0;
            end else begin
              mo_d = mo_q + 4'd1;
            end
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_res_d     = res_ok_q;
          o_year_d    = ly_q;
          o_month_d   = res_m_q;
          o_day_d     = res_d_q;
          o_leap_d    = res_leap_q;
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q        <= y_d;
    m_q        <= m_d;
    d_q        <= d_d;
    ok_q       <= ok_d;
    rem_q      <= rem_d;
    ly_q       <= ly_d;
    w_q        <= w_d;
    mo_q       <= mo_d;
    leap_ph_q  <= leap_ph_d;
    res_m_q    <= res_m_d;
    res_d_q    <= res_d_d;
    res_leap_q <= res_leap_d;
    res_ok_q   <= res_ok_d;
    o_res_q    <= o_res_d;
    o_year_q   <= o_year_d;
    o_month_q  <= o_month_d;
    o_day_q    <= o_day_d;
    o_leap_q   <= o_leap_d;
  end

  assign out_valid_o     = out_valid_q;
  assign valid_res_o     = o_res_q;
  assign lunar_year_o    = o_year_q;
  assign lunar_month_o   = o_month_q;
  assign lunar_day_o     = o_day_q;
  assign is_leap_month_o = o_leap_q;

  assign illegal_out  = out_valid_o && !valid_res_o;
  assign legal_out    = out_valid_o && valid_res_o;
  assign res_zero     = (lunar_year_o == 12'd0) && (lunar_month_o == 4'd0) &&
                        (lunar_day_o == 5'd0) && !is_leap_month_o;
  assign res_in_range = (lunar_month_o inside {[4'd1:LastMonth]}) &&
                        (lunar_day_o inside {[5'd1:MaxLunarDay]});
  assign ly_in_table  = (ly_q >= BaseYear) && (ly_q <= LastYear);
  assign mo_in_year   = (mo_q >= 4'd1) && (mo_q <= LastMonth);

  `S2L_ASSERT_NEXT(a_busy_after_accept, in_xfer, !in_ready_o, "converter still ready after accept")
  `S2L_ASSERT_IMPLIES(a_invalid_zero, illegal_out, res_zero, "illegal date result not zero")
  `S2L_ASSERT_IMPLIES(a_valid_range, legal_out, res_in_range, "lunar month or day out of range")
  `S2L_ASSERT_IMPLIES(a_year_walk_range, state_q == ST_YEAR, ly_in_table, "year walk off the table")
  `S2L_ASSERT_IMPLIES(a_month_walk_range, state_q == ST_MONTH, mo_in_year, "bad month in walk")

endmodule

`default_nettype wire
